@@ hdl/pes_pkg.sv @@
// types and constants shared by the pixel extrema statistics unit
package pes_pkg;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       last_pixel;
  } pix_in_t;

  typedef struct packed {
    logic [2:0]  record_kind;
    logic [11:0] pos_x;
    logic [11:0] pos_y;
    logic [7:0]  pix_red;
    logic [7:0]  pix_green;
    logic [7:0]  pix_blue;
    logic [7:0]  channel_value;
    logic        last_record;
  } rec_out_t;

  typedef struct packed {
    logic [11:0] y;
    logic [11:0] x;
  } place_t;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } color_t;

  typedef struct packed {
    logic [9:0]       bright_sum;
    place_t           bright_place;
    color_t           bright_color;
    logic [9:0]       dark_sum;
    place_t           dark_place;
    color_t           dark_color;
    logic [2:0][7:0]  high;
    place_t [2:0]     high_place;
    logic [2:0][7:0]  low;
    place_t [2:0]     low_place;
  } stats_t;

  localparam int CFG_W = 13;
  localparam logic [CFG_W-1:0] WIDTH_RESET = 13'd640;
  localparam logic [9:0] DARK_SUM_RESET = 10'd765;
  localparam logic [7:0] LOW_RESET = 8'd255;
  localparam int RPTQ_DEPTH = 2;

  localparam logic [2:0] KIND_BRIGHT = 3'd0;
  localparam logic [2:0] KIND_DARK   = 3'd1;
  localparam logic [2:0] KIND_MAX_R  = 3'd2;
  localparam logic [2:0] KIND_MAX_G  = 3'd3;
  localparam logic [2:0] KIND_MAX_B  = 3'd4;
  localparam logic [2:0] KIND_MIN_R  = 3'd5;
  localparam logic [2:0] KIND_MIN_G  = 3'd6;
  localparam logic [2:0] KIND_MIN_B  = 3'd7;

  function automatic stats_t stats_clear();
    stats_t s;
    s = '0;
    s.dark_sum = DARK_SUM_RESET;
    for (int c = 0; c < 3; c++) begin
      s.low[c] = LOW_RESET;
    end
    return s;
  endfunction

endpackage

@@ hdl/pes_front.sv @@
// front end: position counters and extrema trackers, pushes a snapshot per image
module pes_front #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic [pes_pkg::CFG_W-1:0] cfg_wdata,
  input  logic                   in_push,
  input  pes_pkg::pix_in_t       in_pixel,
  output logic                   in_full,
  output logic                   q_push,
  output pes_pkg::stats_t        q_data,
  input  logic                   q_full
);
  import pes_pkg::*;

  localparam int CNTW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int RW   = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int CMPW = (CFG_W > CNTW + 1) ? CFG_W : CNTW + 1;

  logic [CFG_W-1:0] width_r;
  logic [CNTW-1:0]  col_r, col_nxt;
  logic [RW-1:0]    row_r, row_nxt;
  logic             seen_r, seen_nxt;
  stats_t           stats_r, stats_nxt, upd;

  logic             accept;
  logic [2:0][7:0]  ch;
  logic [9:0]       sum;
  place_t           place;
  color_t           color;
  logic [CMPW-1:0]  w_eff;
  logic [CMPW-1:0]  col_plus;

  assign in_full = q_full;
  assign accept  = in_push && !q_full;

  assign ch[0] = in_pixel.red;
  assign ch[1] = in_pixel.green;
  assign ch[2] = in_pixel.blue;
  assign sum   = 10'(in_pixel.red) + 10'(in_pixel.green) + 10'(in_pixel.blue);
  assign color = '{r: in_pixel.red, g: in_pixel.green, b: in_pixel.blue};
  assign place = '{y: 12'(row_r), x: 12'(col_r)};

  always_comb begin
    upd = stats_r;
    if (!seen_r || sum > stats_r.bright_sum) begin
      upd.bright_sum   = sum;
      upd.bright_place = place;
      upd.bright_color = color;
    end
    if (!seen_r || sum < stats_r.dark_sum) begin
      upd.dark_sum   = sum;
      upd.dark_place = place;
      upd.dark_color = color;
    end
    for (int c = 0; c < 3; c++) begin
      if (!seen_r || ch[c] > stats_r.high[c]) begin
        upd.high[c]       = ch[c];
        upd.high_place[c] = place;
      end
      if (!seen_r || ch[c] < stats_r.low[c]) begin
        upd.low[c]       = ch[c];
        upd.low_place[c] = place;
      end
    end
  end

  always_comb begin
    w_eff = CMPW'(width_r);
    if (width_r == '0) begin
      w_eff = CMPW'(1);
    end
    if (w_eff > CMPW'(MAX_WIDTH)) begin
      w_eff = CMPW'(MAX_WIDTH);
    end
    col_plus = CMPW'(col_r) + CMPW'(1);
  end

  always_comb begin
    col_nxt   = col_r;
    row_nxt   = row_r;
    seen_nxt  = seen_r;
    stats_nxt = stats_r;
    if (accept) begin
      if (in_pixel.last_pixel) begin
        col_nxt   = '0;
        row_nxt   = '0;
        seen_nxt  = 1'b0;
        stats_nxt = stats_clear();
      end else begin
        seen_nxt  = 1'b1;
        stats_nxt = upd;
        if (col_plus >= w_eff) begin
          col_nxt = '0;
          if (row_r != RW'(MAX_HEIGHT - 1)) begin
            row_nxt = row_r + RW'(1);
          end
        end else begin
          col_nxt = col_r + CNTW'(1);
        end
      end
    end
  end

  assign q_push = accept && in_pixel.last_pixel;
  assign q_data = upd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r <= WIDTH_RESET;
      col_r   <= '0;
      row_r   <= '0;
      seen_r  <= 1'b0;
      stats_r <= stats_clear();
    end else begin
      if (cfg_we) begin
        width_r <= cfg_wdata;
      end
      col_r   <= col_nxt;
      row_r   <= row_nxt;
      seen_r  <= seen_nxt;
      stats_r <= stats_nxt;
    end
  end

endmodule

@@ hdl/pes_rptq.sv @@
// short queue of finished image snapshots between front and back
module pes_rptq (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_push,
  input  pes_pkg::stats_t q_wdata,
  output logic            q_full,
  input  logic            q_pop,
  output pes_pkg::stats_t q_rdata,
  output logic            q_empty
);
  import pes_pkg::*;

  localparam int PW = (RPTQ_DEPTH > 1) ? $clog2(RPTQ_DEPTH) : 1;
  localparam int CW = $clog2(RPTQ_DEPTH + 1);

  stats_t          mem_r [RPTQ_DEPTH];
  logic [PW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]   cnt_r, cnt_nxt;

  assign q_full  = (cnt_r == CW'(RPTQ_DEPTH));
  assign q_empty = (cnt_r == '0);
  assign q_rdata = mem_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (q_push && !q_pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (!q_push && q_pop) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (q_push) begin
      mem_r[wr_ptr_r] <= q_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (q_push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(RPTQ_DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
      end
      if (q_pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(RPTQ_DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_full |-> !q_push || q_pop)
    else $error("snapshot queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty)
    else $error("snapshot queue underflow");
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(RPTQ_DEPTH))
    else $error("snapshot queue count out of range");

endmodule

@@ hdl/pes_back.sv @@
// back end: serializes a snapshot into eight records behind an output register
module pes_back (
  input  logic               clk,
  input  logic               rst_n,
  input  pes_pkg::stats_t    q_rdata,
  input  logic               q_empty,
  output logic               q_pop,
  output logic               out_empty,
  input  logic               out_pop,
  output pes_pkg::rec_out_t  out_rec
);
  import pes_pkg::*;

  logic      ov_r;
  rec_out_t  rec_r;
  logic [2:0] idx_r;
  logic      load;

  function automatic rec_out_t make_rec(stats_t s, logic [2:0] k);
    rec_out_t r;
    r = '0;
    r.record_kind = k;
    case (k)
      KIND_BRIGHT: begin
        r.pos_x = s.bright_place.x;
        r.pos_y = s.bright_place.y;
        r.pix_red   = s.bright_color.r;
        r.pix_green = s.bright_color.g;
        r.pix_blue  = s.bright_color.b;
      end
      KIND_DARK: begin
        r.pos_x = s.dark_place.x;
        r.pos_y = s.dark_place.y;
        r.pix_red   = s.dark_color.r;
        r.pix_green = s.dark_color.g;
        r.pix_blue  = s.dark_color.b;
      end
      KIND_MAX_R: begin
        r.pos_x = s.high_place[0].x;
        r.pos_y = s.high_place[0].y;
        r.channel_value = s.high[0];
      end
      KIND_MAX_G: begin
        r.pos_x = s.high_place[1].x;
        r.pos_y = s.high_place[1].y;
        r.channel_value = s.high[1];
      end
      KIND_MAX_B: begin
        r.pos_x = s.high_place[2].x;
        r.pos_y = s.high_place[2].y;
        r.channel_value = s.high[2];
      end
      KIND_MIN_R: begin
        r.pos_x = s.low_place[0].x;
        r.pos_y = s.low_place[0].y;
        r.channel_value = s.low[0];
      end
      KIND_MIN_G: begin
        r.pos_x = s.low_place[1].x;
        r.pos_y = s.low_place[1].y;
        r.channel_value = s.low[1];
      end
      KIND_MIN_B: begin
        r.pos_x = s.low_place[2].x;
        r.pos_y = s.low_place[2].y;
        r.channel_value = s.low[2];
        r.last_record = 1'b1;
      end
      default: begin
        r = '0;
      end
    endcase
    return r;
  endfunction

  assign load      = !q_empty && (!ov_r || out_pop);
  assign q_pop     = load && (idx_r == KIND_MIN_B);
  assign out_empty = !ov_r;
  assign out_rec   = rec_r;

  always_ff @(posedge clk) begin
    if (load) begin
      rec_r <= make_rec(q_rdata, idx_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r  <= 1'b0;
      idx_r <= KIND_BRIGHT;
    end else begin
      if (load) begin
        ov_r  <= 1'b1;
        idx_r <= idx_r + 3'd1;
      end else if (out_pop) begin
        ov_r <= 1'b0;
      end
    end
  end

  a_last_kind: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r |-> (rec_r.last_record == (rec_r.record_kind == KIND_MIN_B)))
    else $error("last_record flag does not match record kind");
  a_pop_at_end: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> rec_r.record_kind == KIND_MIN_B && idx_r == KIND_BRIGHT)
    else $error("snapshot released before its eighth record");
  a_kind_seq: assert property (@(posedge clk) disable iff (!rst_n)
    load |=> rec_r.record_kind == $past(idx_r))
    else $error("record kind out of sequence");

endmodule

@@ hdl/pixel_extrema_statistics_unit.sv @@
// top level of the pixel extrema statistics unit
//
//  channel  ports                          handshake
//  -------  -----------------------------  -------------------------------
//  input    in_push in_full in_pixel       taken when in_push && !in_full
//  result   out_empty out_pop out_rec      taken when out_pop && !out_empty
//  config   cfg_we cfg_wdata               written when cfg_we
//
//  one pixel per cycle while in_full is low; the trackers update in the cycle
//  the pixel is taken; the last pixel pushes a snapshot into a two-entry
//  queue; the back end drains eight records, one per cycle while out_pop is
//  high, through an output register; in_full rises only while both snapshots
//  wait: images shorter than eight pixels in a row, or a result side that stalls
//  rst_n is synchronous; it clears counters, trackers, queue and output
module pixel_extrema_statistics_unit #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [pes_pkg::CFG_W-1:0] cfg_wdata,
  input  logic                      in_push,
  input  pes_pkg::pix_in_t          in_pixel,
  output logic                      in_full,
  output logic                      out_empty,
  input  logic                      out_pop,
  output pes_pkg::rec_out_t         out_rec
);
  import pes_pkg::*;

  logic   q_push, q_full, q_pop, q_empty;
  stats_t q_wdata, q_rdata;

  pes_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_push   (in_push),
    .in_pixel  (in_pixel),
    .in_full   (in_full),
    .q_push    (q_push),
    .q_data    (q_wdata),
    .q_full    (q_full)
  );

  pes_rptq u_rptq (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_push  (q_push),
    .q_wdata (q_wdata),
    .q_full  (q_full),
    .q_pop   (q_pop),
    .q_rdata (q_rdata),
    .q_empty (q_empty)
  );

  pes_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_rdata   (q_rdata),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_rec   (out_rec)
  );

endmodule

@@ bench/pixel_extrema_statistics_unit_test.sv @@
// self-checking testbench for the pixel extrema statistics unit
module pixel_extrema_statistics_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import pes_pkg::*;

  localparam int MAX_WIDTH = 4096;
  localparam int MAX_HEIGHT = 4096;
  localparam int SETTLE_CYCLES = 8;
  localparam logic [2:0][2:0] MAX_KINDS = {KIND_MAX_B, KIND_MAX_G, KIND_MAX_R};
  localparam logic [2:0][2:0] MIN_KINDS = {KIND_MIN_B, KIND_MIN_G, KIND_MIN_R};

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_W-1:0] cfg_wdata;
  logic in_push;
  pix_in_t in_pixel;
  logic in_full;
  logic out_empty;
  logic out_pop;
  rec_out_t out_rec;

  pix_in_t pixel_backlog[$];
  rec_out_t awaited_records[$];
  int send_idle_pct;
  int pop_stall_pct;
  bit pixel_taken;
  int mismatches;
  rec_out_t oldest_record;

  // extrema tracker state
  logic [CFG_W-1:0] width_reg;
  logic [11:0] col_now;
  logic [11:0] row_now;
  bit any_pixel;
  logic [9:0] top_sum;
  logic [9:0] bottom_sum;
  place_t top_place;
  place_t bottom_place;
  color_t top_color;
  color_t bottom_color;
  logic [7:0] chan_max[3];
  logic [7:0] chan_min[3];
  place_t chan_max_place[3];
  place_t chan_min_place[3];

  pixel_extrema_statistics_unit #(
    .MAX_WIDTH(MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) u_dut (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_push(in_push),
    .in_pixel(in_pixel),
    .in_full(in_full),
    .out_empty(out_empty),
    .out_pop(out_pop),
    .out_rec(out_rec)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void clear_extrema();
    col_now = '0;
    row_now = '0;
    any_pixel = 1'b0;
    top_sum = '0;
    top_place = '0;
    top_color = '0;
    bottom_sum = 10'd765;
    bottom_place = '0;
    bottom_color = '0;
    for (int c = 0; c < 3; c++) begin
      chan_max[c] = '0;
      chan_max_place[c] = '0;
      chan_min[c] = 8'd255;
      chan_min_place[c] = '0;
    end
  endfunction

  task automatic fold_pixel_into_extrema(input pix_in_t p);
    logic [7:0] ch[3];
    logic [9:0] sum;
    place_t here;
    color_t tint;
    int w;
    rec_out_t rec;
    ch[0] = p.red;
    ch[1] = p.green;
    ch[2] = p.blue;
    sum = {2'b00, p.red} + {2'b00, p.green} + {2'b00, p.blue};
    here.x = col_now;
    here.y = row_now;
    tint = {p.red, p.green, p.blue};
    if (!any_pixel || sum > top_sum) begin
      top_sum = sum;
      top_place = here;
      top_color = tint;
    end
    if (!any_pixel || sum < bottom_sum) begin
      bottom_sum = sum;
      bottom_place = here;
      bottom_color = tint;
    end
    for (int c = 0; c < 3; c++) begin
      if (!any_pixel || ch[c] > chan_max[c]) begin
        chan_max[c] = ch[c];
        chan_max_place[c] = here;
      end
      if (!any_pixel || ch[c] < chan_min[c]) begin
        chan_min[c] = ch[c];
        chan_min_place[c] = here;
      end
    end
    any_pixel = 1'b1;
    w = int'(width_reg);
    if (w == 0) w = 1;
    if (w > MAX_WIDTH) w = MAX_WIDTH;
    if (int'(col_now) + 1 >= w) begin
      col_now = '0;
      if (int'(row_now) + 1 < MAX_HEIGHT) row_now = row_now + 12'd1;
    end else begin
      col_now = col_now + 12'd1;
    end
    if (p.last_pixel) begin
      rec = '0;
      rec.record_kind = KIND_BRIGHT;
      rec.pos_x = top_place.x;
      rec.pos_y = top_place.y;
      rec.pix_red = top_color.r;
      rec.pix_green = top_color.g;
      rec.pix_blue = top_color.b;
      awaited_records.push_back(rec);
      rec = '0;
      rec.record_kind = KIND_DARK;
      rec.pos_x = bottom_place.x;
      rec.pos_y = bottom_place.y;
      rec.pix_red = bottom_color.r;
      rec.pix_green = bottom_color.g;
      rec.pix_blue = bottom_color.b;
      awaited_records.push_back(rec);
      for (int c = 0; c < 3; c++) begin
        rec = '0;
        rec.record_kind = MAX_KINDS[c];
        rec.pos_x = chan_max_place[c].x;
        rec.pos_y = chan_max_place[c].y;
        rec.channel_value = chan_max[c];
        awaited_records.push_back(rec);
      end
      for (int c = 0; c < 3; c++) begin
        rec = '0;
        rec.record_kind = MIN_KINDS[c];
        rec.pos_x = chan_min_place[c].x;
        rec.pos_y = chan_min_place[c].y;
        rec.channel_value = chan_min[c];
        rec.last_record = (MIN_KINDS[c] == KIND_MIN_B);
        awaited_records.push_back(rec);
      end
      clear_extrema();
    end
  endtask

  task automatic compare_field(input string name, input logic [11:0] got,
                               input logic [11:0] want);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    pixel_taken = rst_n && in_push && !in_full;
    if (rst_n && out_pop && !out_empty) begin
      if (awaited_records.size() == 0) begin
        mismatches++;
        $display("%0t: record expected none actual %p", $time, out_rec);
      end else begin
        oldest_record = awaited_records.pop_front();
        compare_field("record_kind", 12'(out_rec.record_kind),
                      12'(oldest_record.record_kind));
        compare_field("pos_x", out_rec.pos_x, oldest_record.pos_x);
        compare_field("pos_y", out_rec.pos_y, oldest_record.pos_y);
        compare_field("pix_red", 12'(out_rec.pix_red), 12'(oldest_record.pix_red));
        compare_field("pix_green", 12'(out_rec.pix_green), 12'(oldest_record.pix_green));
        compare_field("pix_blue", 12'(out_rec.pix_blue), 12'(oldest_record.pix_blue));
        compare_field("channel_value", 12'(out_rec.channel_value),
                      12'(oldest_record.channel_value));
        compare_field("last_record", 12'(out_rec.last_record),
                      12'(oldest_record.last_record));
      end
    end
    if (pixel_taken) fold_pixel_into_extrema(in_pixel);
  end

  // pixel driver: holds a transaction until it is taken; out_pop is drawn at random
  always @(negedge clk) begin
    if (!in_push || pixel_taken) begin
      if (pixel_backlog.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        in_pixel <= pixel_backlog.pop_front();
        in_push <= 1'b1;
      end else begin
        in_push <= 1'b0;
      end
    end
    out_pop <= ($urandom_range(99) >= pop_stall_pct);
  end

  function automatic void queue_pixel(input int r, input int g, input int b,
                                      input bit last);
    pix_in_t p;
    p.red = 8'(r);
    p.green = 8'(g);
    p.blue = 8'(b);
    p.last_pixel = last;
    pixel_backlog.push_back(p);
  endfunction

  function automatic void queue_image(input int len, input int lo, input int hi);
    for (int i = 0; i < len; i++) begin
      queue_pixel($urandom_range(hi, lo), $urandom_range(hi, lo),
                  $urandom_range(hi, lo), i == len - 1);
    end
  endfunction

  task automatic wait_drained();
    while (pixel_backlog.size() != 0 || in_push || awaited_records.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_width(input int value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= CFG_W'(value);
    @(negedge clk);
    cfg_we <= 1'b0;
    width_reg = CFG_W'(value);
  endtask

  task automatic random_images(input int idle_pct, input int stall_pct, input int count);
    int sent;
    int len;
    int lo;
    int hi;
    send_idle_pct = idle_pct;
    pop_stall_pct = stall_pct;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(5) == 0) begin
        wait_drained();
        if ($urandom_range(9) == 0) write_width($urandom_range(8191, 0));
        else write_width($urandom_range(20, 1));
      end
      len = ($urandom_range(3) == 0) ? 1 : $urandom_range(12, 2);
      if ($urandom_range(2) == 0) begin
        lo = $urandom_range(252, 0);
        hi = lo + 3;
      end else begin
        lo = 0;
        hi = 255;
      end
      queue_image(len, lo, hi);
      sent += len;
    end
    wait_drained();
  endtask

  initial begin
    #5_000_000;
    $display("tb: failure");
    $finish;
  end

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_push = 1'b0;
    in_pixel = '0;
    out_pop = 1'b0;
    send_idle_pct = 0;
    pop_stall_pct = 0;
    mismatches = 0;
    width_reg = WIDTH_RESET;
    clear_extrema();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // first pixel at full scale, then ties
    queue_pixel(255, 255, 255, 0);
    queue_pixel(255, 255, 255, 0);
    queue_pixel(0, 0, 0, 0);
    queue_pixel(0, 0, 0, 0);
    queue_pixel(10, 200, 30, 1);
    queue_pixel(0, 0, 0, 1);
    queue_pixel(0, 0, 0, 0);
    queue_pixel(255, 0, 0, 0);
    queue_pixel(0, 255, 0, 0);
    queue_pixel(0, 0, 255, 0);
    queue_pixel(255, 0, 0, 0);
    queue_pixel(0, 255, 255, 0);
    queue_pixel(128, 128, 128, 1);
    queue_pixel(255, 255, 255, 1);
    wait_drained();

    // width shrinks while an image is open
    write_width(8);
    for (int i = 0; i < 6; i++) queue_pixel(i * 40, 255 - i * 40, 7 * i, 0);
    wait_drained();
    write_width(3);
    queue_pixel(90, 91, 92, 0);
    queue_pixel(3, 250, 3, 0);
    queue_pixel(200, 1, 100, 1);
    wait_drained();
    write_width(4096);
    queue_pixel(1, 2, 3, 0);
    queue_pixel(4, 5, 6, 1);
    wait_drained();

    random_images(0, 0, 22);
    random_images(45, 0, 22);
    random_images(0, 45, 22);
    random_images(37, 37, 22);

    // zero width acts as one column
    write_width(0);
    send_idle_pct = 37;
    pop_stall_pct = 37;
    queue_pixel(255, 255, 255, 0);
    queue_pixel(0, 0, 0, 0);
    queue_pixel(1, 254, 1, 1);
    wait_drained();

    // oversized width clamps to the widest row
    write_width(8191);
    queue_image(5, 0, 255);
    wait_drained();

    random_images(45, 45, 18);
    wait_drained();

    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

@@ files.f @@
hdl/pes_pkg.sv
hdl/pes_front.sv
hdl/pes_rptq.sv
hdl/pes_back.sv
hdl/pixel_extrema_statistics_unit.sv
bench/pixel_extrema_statistics_unit_test.sv
